// File: rtl/core/process_slot_table_ready_queue_macros.svh
// Assertion macros used by the slot table checker file.
`ifndef PROCESS_SLOT_TABLE_READY_QUEUE_MACROS_SVH
`define PROCESS_SLOT_TABLE_READY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSTRQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PSTRQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pstrq_pkg.sv
// Shared types, widths and codes of the process slot table with ready queue.
`default_nettype none

package pstrq_pkg;

  // Pool size and derived widths
  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int LINK_W     = $clog2(SLOT_COUNT + 1);

  // Fixed field widths of the request and result
  localparam int OPCODE_W = 2;
  localparam int SLOT_FW  = 3;
  localparam int STATUS_W = 2;

  typedef logic [SLOT_W-1:0] idx_t;
  typedef logic [LINK_W-1:0] link_t;

  // Link value that marks the end of the list
  localparam link_t LINK_NIL = LINK_W'(SLOT_COUNT);

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_ENQUEUE = 2'd2,
    OP_DEQUEUE = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_EMPTY   = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: rtl/core/process_slot_table_ready_queue.sv
// Process slot table with a doubly linked ready queue held in link memories.
//
// One request is taken at a time; in_stall is high from acceptance until the
// result has been loaded into the output register, and a new request may be
// accepted while that result still waits on out_stall. From acceptance, an
// allocate and a dequeue of an empty queue go straight to S_DONE; a release
// of an unqueued slot or an enqueue of an already queued slot pass S_READ
// first; a release or dequeue that unlinks a slot passes S_READ, S_UNLINK and
// S_CLEAR, and an enqueue that appends one S_READ, S_APPEND and S_LINK. S_DONE
// loads the result once the output register is free. These steps come from
// the registered read of the next/prev link memories and from their single
// write port, which takes each link update of a memory in a state of its own.
// Links read as the end-of-list marker until first written, tracked by one
// valid flop per entry, so no clearing pass runs after reset.
`default_nettype none

module process_slot_table_ready_queue
  import pstrq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [OPCODE_W-1:0] in_opcode,
  input  wire logic [SLOT_FW-1:0]  in_slot,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [STATUS_W-1:0]      out_status,
  output logic [SLOT_FW-1:0]       out_result_slot
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UNLINK,
    S_CLEAR,
    S_APPEND,
    S_LINK,
    S_DONE
  } state_t;

  // Control and state registers
  state_t                  state_r, state_nxt;
  opcode_t                 op_r, op_nxt;
  idx_t                    cur_r, cur_nxt;
  link_t                   head_r, head_nxt;
  link_t                   tail_r, tail_nxt;
  link_t                   nlink_r, nlink_nxt;
  link_t                   plink_r, plink_nxt;
  logic [SLOT_COUNT-1:0]   in_use_r, in_use_nxt;
  logic [SLOT_COUNT-1:0]   next_vld_r, next_vld_nxt;
  logic [SLOT_COUNT-1:0]   prev_vld_r, prev_vld_nxt;
  logic                    next_rdv_r, prev_rdv_r;
  status_t                 res_status_r, res_status_nxt;
  logic [SLOT_FW-1:0]      res_slot_r, res_slot_nxt;
  logic                    out_valid_r, out_valid_nxt;
  status_t                 out_status_r, out_status_nxt;
  logic [SLOT_FW-1:0]      out_slot_r, out_slot_nxt;

  // Link memories
  link_t                   next_mem [SLOT_COUNT];
  link_t                   prev_mem [SLOT_COUNT];
  link_t                   next_rd_r, prev_rd_r;
  idx_t                    rd_addr;
  logic                    next_we, prev_we;
  idx_t                    next_wa, prev_wa;
  link_t                   next_wd, prev_wd;

  // Request decode and derived values
  logic                    in_acc;
  logic                    in_rng;
  idx_t                    in_idx;
  logic                    any_free;
  idx_t                    free_idx;
  link_t                   rd_next, rd_prev;
  logic                    queued;

  assign in_stall        = (state_r != S_IDLE);
  assign in_acc          = in_valid && !in_stall;
  assign in_rng          = (int'(in_slot) < SLOT_COUNT);
  assign in_idx          = SLOT_W'(in_slot);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_slot = out_slot_r;

  // Links that were never written read as the end marker
  assign rd_next = next_rdv_r ? next_rd_r : LINK_NIL;
  assign rd_prev = prev_rdv_r ? prev_rd_r : LINK_NIL;
  assign queued  = (head_r == LINK_W'(cur_r)) || (rd_prev != LINK_NIL);

  // Read the entry of the slot named by the request, or of the head on dequeue
  always_comb begin
    if (state_r == S_IDLE && opcode_t'(in_opcode) == OP_DEQUEUE) begin
      rd_addr = head_r[SLOT_W-1:0];
    end else if (state_r == S_IDLE) begin
      rd_addr = in_idx;
    end else begin
      rd_addr = cur_r;
    end
  end

  // Find the lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        any_free = 1'b1;
        free_idx = SLOT_W'(i);
      end
    end
  end

  // Sequence each request through its link reads and writes
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    cur_nxt        = cur_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    nlink_nxt      = nlink_r;
    plink_nxt      = plink_r;
    in_use_nxt     = in_use_r;
    next_vld_nxt   = next_vld_r;
    prev_vld_nxt   = prev_vld_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    next_we        = 1'b0;
    prev_we        = 1'b0;
    next_wa        = cur_r;
    prev_wa        = cur_r;
    next_wd        = LINK_NIL;
    prev_wd        = LINK_NIL;

    // Drop the result once taken
    out_valid_nxt = out_valid_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt         = opcode_t'(in_opcode);
          cur_nxt        = in_idx;
          res_status_nxt = STATUS_OK;
          res_slot_nxt   = '0;
          state_nxt      = S_DONE;
          case (opcode_t'(in_opcode))
            OP_ALLOC: begin
              if (any_free) begin
                in_use_nxt[free_idx] = 1'b1;
                res_slot_nxt         = SLOT_FW'(free_idx);
              end else begin
                res_status_nxt = STATUS_NO_FREE;
              end
            end
            OP_RELEASE: begin
              if (in_rng) begin
                in_use_nxt[in_idx] = 1'b0;
                state_nxt          = S_READ;
              end
            end
            OP_ENQUEUE: begin
              if (in_rng) begin
                state_nxt = S_READ;
              end
            end
            OP_DEQUEUE: begin
              if (head_r == LINK_NIL) begin
                res_status_nxt = STATUS_EMPTY;
              end else begin
                cur_nxt      = head_r[SLOT_W-1:0];
                res_slot_nxt = SLOT_FW'(head_r[SLOT_W-1:0]);
                state_nxt    = S_READ;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      // Hold the slot's links and decide whether it sits in the queue
      S_READ: begin
        nlink_nxt = rd_next;
        plink_nxt = rd_prev;
        if (op_r == OP_ENQUEUE) begin
          state_nxt = queued ? S_DONE : S_APPEND;
        end else begin
          state_nxt = queued ? S_UNLINK : S_DONE;
        end
      end

      // Bridge the neighbors around the slot
      S_UNLINK: begin
        if (plink_r != LINK_NIL) begin
          next_we = 1'b1;
          next_wa = plink_r[SLOT_W-1:0];
          next_wd = nlink_r;
        end else begin
          head_nxt = nlink_r;
        end
        if (nlink_r != LINK_NIL) begin
          prev_we = 1'b1;
          prev_wa = nlink_r[SLOT_W-1:0];
          prev_wd = plink_r;
        end else begin
          tail_nxt = plink_r;
        end
        state_nxt = S_CLEAR;
      end

      // Clear the removed slot's links
      S_CLEAR: begin
        next_we   = 1'b1;
        prev_we   = 1'b1;
        state_nxt = S_DONE;
      end

      // Point the new slot back at the old tail and end its next link
      S_APPEND: begin
        next_we   = 1'b1;
        prev_we   = 1'b1;
        prev_wd   = tail_r;
        state_nxt = S_LINK;
      end

      // Hook the new slot behind the old tail, or make it the head of an empty queue, and advance the tail
      S_LINK: begin
        if (tail_r != LINK_NIL) begin
          next_we = 1'b1;
          next_wa = tail_r[SLOT_W-1:0];
          next_wd = LINK_W'(cur_r);
        end else begin
          head_nxt = LINK_W'(cur_r);
        end
        tail_nxt  = LINK_W'(cur_r);
        state_nxt = S_DONE;
      end

      // Load the result once the output register is free
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Mark written link entries valid
    if (next_we) begin
      next_vld_nxt[next_wa] = 1'b1;
    end
    if (prev_we) begin
      prev_vld_nxt[prev_wa] = 1'b1;
    end
  end

  // Hold state, control and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= LINK_NIL;
      tail_r      <= LINK_NIL;
      in_use_r    <= '0;
      next_vld_r  <= '0;
      prev_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      in_use_r    <= in_use_nxt;
      next_vld_r  <= next_vld_nxt;
      prev_vld_r  <= prev_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    cur_r        <= cur_nxt;
    nlink_r      <= nlink_nxt;
    plink_r      <= plink_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    next_rdv_r   <= next_vld_r[rd_addr];
    prev_rdv_r   <= prev_vld_r[rd_addr];
  end

  // Next-link memory, registered read
  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    next_rd_r <= next_mem[rd_addr];
  end

  // Prev-link memory, registered read
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    prev_rd_r <= prev_mem[rd_addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/pstrq_checker.sv
// Port-level checks of the process slot table, bound to the top level.
`default_nettype none

`include "process_slot_table_ready_queue_macros.svh"

module pstrq_checker
  import pstrq_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [SLOT_FW-1:0]  out_result_slot
);

  // A stalled result holds
  `PSTRQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status) && $stable(out_result_slot), "stalled result changed")

  // Failed requests carry slot zero
  `PSTRQ_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && (out_status != STATUS_OK), out_result_slot == '0, "failed result with nonzero slot")

  // One request at a time: stall right after acceptance
  `PSTRQ_ASSERT_NEXT(a_one_busy, clk, rst_n, in_valid && !in_stall, in_stall, "request accepted while busy")

  // With no result held, none shows in the cycle right after acceptance
  `PSTRQ_ASSERT_NEXT(a_no_early, clk, rst_n, in_valid && !in_stall && !out_valid, !out_valid, "result appeared too early")

endmodule

bind process_slot_table_ready_queue pstrq_checker u_pstrq_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_result_slot (out_result_slot)
);

`default_nettype wire
